// File: rtl/rwhp_pkg.sv
// shared types and constants for the riff wave header parser
`timescale 1ns / 1ps

package rwhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
    localparam logic [31:0] TAG_BYTES     = 32'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_RIFF      = 8'b0000_0010,
        PH_FILELEN   = 8'b0000_0100,
        PH_WAVE      = 8'b0000_1000,
        PH_CHUNK_TAG = 8'b0001_0000,
        PH_CHUNK_LEN = 8'b0010_0000,
        PH_FMT_BODY  = 8'b0100_0000,
        PH_SKIP      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] format_code;
        logic [15:0] channel_count;
        logic [31:0] samples_per_second;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
    } result_t;

endpackage

// File: rtl/rwhp_parser.sv
// byte-step parse state machine with its field capture registers
`timescale 1ns / 1ps

module rwhp_parser
    import rwhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    input  logic        stream_end,
    output logic        res_hit,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] depth_reg, depth_next;

    always_comb
    begin
        phase_t      p;
        logic [31:0] c;
        logic [31:0] c_inc;

        // a file start restarts everything before the byte is used
        p          = file_start ? PH_RIFF : phase_reg;
        c          = file_start ? '0 : cnt_reg;
        tag_next   = file_start ? '0 : tag_reg;
        len_next   = file_start ? '0 : len_reg;
        fmt_next   = file_start ? '0 : fmt_reg;
        chan_next  = file_start ? '0 : chan_reg;
        rate_next  = file_start ? '0 : rate_reg;
        depth_next = file_start ? '0 : depth_reg;
        c_inc      = c + 32'd1;
        phase_next = p;
        cnt_next   = c;
        res_hit    = 1'b0;
        res        = '0;

        if (p == PH_IDLE)
        begin
            res_hit = 1'b0;
        end
        else if (stream_end)
        begin
            res_hit    = 1'b1;
            res.status = (p == PH_RIFF) ? ST_INVALID : ST_EARLY_END;
            phase_next = PH_IDLE;
            cnt_next   = '0;
        end
        else
        begin
            case (p)
                PH_RIFF, PH_WAVE, PH_CHUNK_TAG:
                begin
                    tag_next = {tag_next[23:0], data_byte};
                    cnt_next = c_inc;
                    if (c_inc >= TAG_BYTES)
                    begin
                        cnt_next = '0;
                        if (p == PH_RIFF)
                        begin
                            if (tag_next != TAG_RIFF)
                            begin
                                res_hit    = 1'b1;
                                res.status = ST_INVALID;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_FILELEN;
                            end
                        end
                        else if (p == PH_WAVE)
                        begin
                            if (tag_next != TAG_WAVE)
                            begin
                                res_hit    = 1'b1;
                                res.status = ST_INVALID;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_CHUNK_TAG;
                            end
                        end
                        else
                        begin
                            phase_next = PH_CHUNK_LEN;
                        end
                    end
                end
                PH_FILELEN:
                begin
                    cnt_next = c_inc;
                    if (c_inc >= TAG_BYTES)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_WAVE;
                    end
                end
                PH_CHUNK_LEN:
                begin
                    // little-endian length, first byte ends up lowest
                    len_next = {data_byte, len_next[31:8]};
                    cnt_next = c_inc;
                    if (c_inc >= TAG_BYTES)
                    begin
                        cnt_next = '0;
                        if (tag_next == TAG_FMT)
                        begin
                            if (len_next != FMT_CHUNK_LEN)
                            begin
                                res_hit    = 1'b1;
                                res.status = ST_INVALID;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_FMT_BODY;
                            end
                        end
                        else if (tag_next == TAG_DATA)
                        begin
                            res_hit                = 1'b1;
                            res.status             = ST_OK;
                            res.format_code        = fmt_next;
                            res.channel_count      = chan_next;
                            res.samples_per_second = rate_next;
                            res.bits_per_sample    = depth_next;
                            res.data_length        = len_next;
                            phase_next             = PH_IDLE;
                        end
                        else if (len_next == '0)
                        begin
                            phase_next = PH_CHUNK_TAG;
                        end
                        else
                        begin
                            cnt_next   = len_next;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_FMT_BODY:
                begin
                    // byte rate and block align (bytes 8 to 13) are dropped
                    if (c < 32'd2)
                        fmt_next = {data_byte, fmt_next[15:8]};
                    else if (c < 32'd4)
                        chan_next = {data_byte, chan_next[15:8]};
                    else if (c < 32'd8)
                        rate_next = {data_byte, rate_next[31:8]};
                    else if (c >= 32'd14)
                        depth_next = {data_byte, depth_next[15:8]};
                    cnt_next = c_inc;
                    if (c_inc >= FMT_CHUNK_LEN)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_CHUNK_TAG;
                    end
                end
                PH_SKIP:
                begin
                    if (c != '0)
                        cnt_next = c - 32'd1;
                    if (cnt_next == '0)
                        phase_next = PH_CHUNK_TAG;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            fmt_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            depth_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            fmt_reg   <= fmt_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            depth_reg <= depth_next;
        end
    end

endmodule

// File: rtl/rwhp_out_reg.sv
// result register that holds one result transaction until it is taken
`timescale 1ns / 1ps

module rwhp_out_reg
    import rwhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: rtl/riff_wave_header_parser_top.sv
// top level of the riff wave header parser
//
// input channel: one file byte per transaction (data_byte), with file_start
// marking the first byte of a file and stream_end marking the end of the
// stream (no byte carried then). in_valid / in_stall handshake.
// output channel: at most one result transaction per file, with status and
// the captured fmt fields and data chunk length. out_valid / out_stall.
// throughput: one input byte per cycle while in_stall is low; each byte
// is one step of the parse state machine, its next state combinational.
// a result appears on the outputs in the cycle after the byte that
// completes the data chunk header, a bad tag or fmt length, or stream_end.
// while a result sits in the output register and the receiver stalls,
// in_stall is raised so no byte is lost; otherwise bytes keep flowing.
// after a result the parser drops bytes until the next file_start.
// reset: the parser waits for a file start and the output register is empty.
`timescale 1ns / 1ps

module riff_wave_header_parser_top
    import rwhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] format_code,
    output logic [15:0] channel_count,
    output logic [31:0] samples_per_second,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_length
);

    logic    step;
    logic    res_hit;
    result_t res;
    result_t out_res;

    assign in_stall = out_valid && out_stall;
    assign step     = in_valid && !in_stall;

    rwhp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (data_byte),
        .file_start (file_start),
        .stream_end (stream_end),
        .res_hit    (res_hit),
        .res        (res)
    );

    rwhp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_hit),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign status             = out_res.status;
    assign format_code        = out_res.format_code;
    assign channel_count      = out_res.channel_count;
    assign samples_per_second = out_res.samples_per_second;
    assign bits_per_sample    = out_res.bits_per_sample;
    assign data_length        = out_res.data_length;

endmodule

// File: rtl/rwhp_checker.sv
// port-level checks for the riff wave header parser, bound to the top level
`timescale 1ns / 1ps

module rwhp_checker
    import rwhp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] format_code,
    input logic [15:0] channel_count,
    input logic [31:0] samples_per_second,
    input logic [15:0] bits_per_sample,
    input logic [31:0] data_length
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(format_code) && $stable(data_length)
            && $stable(samples_per_second))
        else $error("stalled result changed");

    // input is held back only while a result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a pending result");

    // failure results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> format_code == '0 && channel_count == '0
            && samples_per_second == '0 && bits_per_sample == '0 && data_length == '0)
        else $error("failure result with nonzero fields");

    // a taken result with no new byte accepted leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
        else $error("result repeated");

endmodule

bind riff_wave_header_parser_top rwhp_checker u_chk (.*);
